FILE: hdl/ldseq_pkg.sv
package ldseq_pkg;

  // Field widths
  localparam int AltW     = 24;
  localparam int VelW     = 16;
  localparam int AccW     = 20;
  localparam int TimeW    = 64;
  localparam int ThrW     = 16;
  localparam int PhaseW   = 2;
  localparam int TgtW     = 14;
  localparam int CfgAltW  = 17;

  // Configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  typedef logic [PhaseW-1:0] phase_t;
  typedef logic [2:0]        reg_idx_t;

  // Landing phases
  localparam phase_t PH_DESCEND  = 2'd0;
  localparam phase_t PH_FINAL    = 2'd1;
  localparam phase_t PH_COMPLETE = 2'd2;

  // Register map (word index)
  localparam reg_idx_t REG_RATE_TARGET   = 3'd0;
  localparam reg_idx_t REG_NEUTRAL_THR   = 3'd1;
  localparam reg_idx_t REG_RATE_GAIN     = 3'd2;
  localparam reg_idx_t REG_THR_MIN       = 3'd3;
  localparam reg_idx_t REG_THR_MAX       = 3'd4;
  localparam reg_idx_t REG_FINAL_THR     = 3'd5;
  localparam reg_idx_t REG_FINAL_ALT     = 3'd6;
  localparam reg_idx_t REG_TOUCHDOWN_ALT = 3'd7;

  // Register reset values
  localparam logic signed [TgtW-1:0] RST_RATE_TARGET   = -14'sd500;
  localparam logic [ThrW-1:0]        RST_NEUTRAL_THR   = 16'd32768;
  localparam logic [ThrW-1:0]        RST_RATE_GAIN     = 16'd32768;
  localparam logic [ThrW-1:0]        RST_THR_MIN       = 16'd13107;
  localparam logic [ThrW-1:0]        RST_THR_MAX       = 16'd45875;
  localparam logic [ThrW-1:0]        RST_FINAL_THR     = 16'd9830;
  localparam logic [CfgAltW-1:0]     RST_FINAL_ALT     = 17'd2000;
  localparam logic [CfgAltW-1:0]     RST_TOUCHDOWN_ALT = 17'd300;

  // Touchdown window on vertical specific force, -2 <= a - g < 2 m/s^2
  localparam logic signed [AccW-1:0] ACCEL_TOUCH_LO = 20'sd7807;
  localparam logic signed [AccW-1:0] ACCEL_TOUCH_HI = 20'sd11806;

  // Disarm delay after touchdown, microseconds
  localparam logic [TimeW-1:0] DISARM_DELAY_US = 64'd1000000;

  // Rounding offset and divide-by-1000 by reciprocal: floor(u/1000) = (u*RECIP) >> 36,
  // exact for 0 <= u < 2^26
  localparam logic signed [34:0] ROUND_HALF   = 35'sd500;
  localparam logic signed [34:0] ROUND_SPAN   = 35'sd65536000;
  localparam logic [26:0]        RECIP_1000   = 27'd68719477;
  localparam int                 RECIP_SHIFT  = 36;

endpackage

FILE: hdl/ldseq_if.sv
// Input channel: one control tick per word
interface ldseq_in_if import ldseq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   enter_mode;
  logic signed [AltW-1:0] altitude;
  logic signed [VelW-1:0] velocity_down;
  logic signed [AccW-1:0] accel_vertical;
  logic [TimeW-1:0]       now_us;

  modport source (
    output valid, enter_mode, altitude, velocity_down, accel_vertical, now_us,
    input  ready
  );
  modport sink (
    input  valid, enter_mode, altitude, velocity_down, accel_vertical, now_us,
    output ready
  );
endinterface

// Result channel: one command word per tick
interface ldseq_out_if import ldseq_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ThrW-1:0] throttle;
  phase_t          phase;
  logic            disarm;

  modport source (
    output valid, throttle, phase, disarm,
    input  ready
  );
  modport sink (
    input  valid, throttle, phase, disarm,
    output ready
  );
endinterface

FILE: hdl/landing_descent_sequencer_core.sv
// Landing descent sequencer.
// in_chan carries one control tick per word (mode entry flag, altitude, down
// velocity, vertical specific force, microsecond time); out_chan returns one
// word per tick with throttle, the updated phase and the disarm request.
// Both channels use valid/ready; a word moves when both are high.
// Stages: input register, multiply stage, rounding stage, output register.
// Throughput: one tick per cycle unless the receiver stalls. The phase and
// touchdown state is updated in the first stage, so consecutive ticks see
// each other's state without bubbles.
// When the receiver stalls with a result pending, the whole pipeline holds
// and in_chan.ready drops in the same cycle; ready is high whenever the
// output register is empty or being taken.
// Configuration registers sit on the APB-style cfg_ port at byte address
// 4*index, written in the access cycle; pready is always high. Write them
// only while the pipeline is empty.
// Reset (synchronous, active low) empties the pipeline, returns the phase
// to descend, clears the touchdown time and loads register defaults.
module landing_descent_sequencer_core import ldseq_pkg::*; #(
  parameter logic [TimeW-1:0] DISARM_DELAY = DISARM_DELAY_US
) (
  input  logic              clk,
  input  logic              rst_n,
  ldseq_in_if.sink          in_chan,
  ldseq_out_if.source       out_chan,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  // ---------------- configuration registers ----------------
  logic signed [TgtW-1:0] rate_target_r;
  logic [ThrW-1:0]        neutral_r;
  logic [ThrW-1:0]        gain_r;
  logic [ThrW-1:0]        thr_min_r;
  logic [ThrW-1:0]        thr_max_r;
  logic [ThrW-1:0]        final_thr_r;
  logic [CfgAltW-1:0]     final_alt_r;
  logic [CfgAltW-1:0]     td_alt_r;

  reg_idx_t cfg_idx;
  logic     cfg_we;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_target_r <= RST_RATE_TARGET;
      neutral_r     <= RST_NEUTRAL_THR;
      gain_r        <= RST_RATE_GAIN;
      thr_min_r     <= RST_THR_MIN;
      thr_max_r     <= RST_THR_MAX;
      final_thr_r   <= RST_FINAL_THR;
      final_alt_r   <= RST_FINAL_ALT;
      td_alt_r      <= RST_TOUCHDOWN_ALT;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_RATE_TARGET:   rate_target_r <= $signed(cfg_pwdata[TgtW-1:0]);
        REG_NEUTRAL_THR:   neutral_r     <= cfg_pwdata[ThrW-1:0];
        REG_RATE_GAIN:     gain_r        <= cfg_pwdata[ThrW-1:0];
        REG_THR_MIN:       thr_min_r     <= cfg_pwdata[ThrW-1:0];
        REG_THR_MAX:       thr_max_r     <= cfg_pwdata[ThrW-1:0];
        REG_FINAL_THR:     final_thr_r   <= cfg_pwdata[ThrW-1:0];
        REG_FINAL_ALT:     final_alt_r   <= cfg_pwdata[CfgAltW-1:0];
        REG_TOUCHDOWN_ALT: td_alt_r      <= cfg_pwdata[CfgAltW-1:0];
        default: ;
      endcase
    end
  end

  // read-back
  always_comb begin
    case (cfg_idx)
      REG_RATE_TARGET:   cfg_prdata = {{(CFG_DW-TgtW){rate_target_r[TgtW-1]}}, rate_target_r};
      REG_NEUTRAL_THR:   cfg_prdata = {{(CFG_DW-ThrW){1'b0}}, neutral_r};
      REG_RATE_GAIN:     cfg_prdata = {{(CFG_DW-ThrW){1'b0}}, gain_r};
      REG_THR_MIN:       cfg_prdata = {{(CFG_DW-ThrW){1'b0}}, thr_min_r};
      REG_THR_MAX:       cfg_prdata = {{(CFG_DW-ThrW){1'b0}}, thr_max_r};
      REG_FINAL_THR:     cfg_prdata = {{(CFG_DW-ThrW){1'b0}}, final_thr_r};
      REG_FINAL_ALT:     cfg_prdata = {{(CFG_DW-CfgAltW){1'b0}}, final_alt_r};
      REG_TOUCHDOWN_ALT: cfg_prdata = {{(CFG_DW-CfgAltW){1'b0}}, td_alt_r};
      default:           cfg_prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic out_valid_r;
  logic adv;

  // whole pipeline moves unless a result waits on a stalled receiver
  assign adv           = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv;

  // ---------------- stage 1: input register ----------------
  logic                   s1_valid_r;
  logic                   s1_enter_r;
  logic signed [AltW-1:0] s1_alt_r;
  logic signed [VelW-1:0] s1_vel_r;
  logic signed [AccW-1:0] s1_acc_r;
  logic [TimeW-1:0]       s1_now_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_enter_r <= in_chan.enter_mode;
      s1_alt_r   <= in_chan.altitude;
      s1_vel_r   <= in_chan.velocity_down;
      s1_acc_r   <= in_chan.accel_vertical;
      s1_now_r   <= in_chan.now_us;
    end
  end

  // ---------------- stage 1 logic: phase update, rate product ----------------
  phase_t           phase_r;
  phase_t           phase_cur;
  phase_t           phase_nxt;
  logic [TimeW-1:0] touchdown_r;
  logic [TimeW-1:0] touchdown_nxt;
  logic [TimeW-1:0] elapsed;
  logic             below_final;
  logic             touch_ok;
  logic             touch_hit;
  logic             s1_disarm;

  assign phase_cur   = s1_enter_r ? PH_DESCEND : phase_r;
  assign below_final = s1_alt_r < $signed({{(AltW-CfgAltW){1'b0}}, final_alt_r});
  assign touch_ok    = (s1_alt_r < $signed({{(AltW-CfgAltW){1'b0}}, td_alt_r}))
                       && (s1_acc_r >= ACCEL_TOUCH_LO) && (s1_acc_r <= ACCEL_TOUCH_HI);

  always_comb begin
    touch_hit = 1'b0;
    case (phase_cur)
      PH_DESCEND: phase_nxt = below_final ? PH_FINAL : PH_DESCEND;
      PH_FINAL: begin
        touch_hit = touch_ok;
        phase_nxt = touch_ok ? PH_COMPLETE : PH_FINAL;
      end
      default:    phase_nxt = PH_COMPLETE;
    endcase
  end

  // touchdown tick stamps the time, so its own elapsed time is zero
  assign touchdown_nxt = touch_hit ? s1_now_r : touchdown_r;
  assign elapsed       = s1_now_r - touchdown_nxt;
  assign s1_disarm     = (phase_nxt == PH_COMPLETE) && (elapsed > DISARM_DELAY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_DESCEND;
      touchdown_r <= '0;
    end else if (adv && s1_valid_r) begin
      phase_r     <= phase_nxt;
      touchdown_r <= touchdown_nxt;
    end
  end

  // rate error (mm/s) times gain
  logic signed [VelW:0]     rate_err;
  logic signed [VelW:0]     gain_s;
  logic signed [2*VelW+1:0] s1_prod;

  assign rate_err = $signed({{(VelW+1-TgtW){rate_target_r[TgtW-1]}}, rate_target_r})
                    + $signed({s1_vel_r[VelW-1], s1_vel_r});
  assign gain_s   = $signed({1'b0, gain_r});
  assign s1_prod  = $signed({{(VelW+1){rate_err[VelW]}}, rate_err})
                    * $signed({{(VelW+1){1'b0}}, gain_s});

  // ---------------- stage 2 ----------------
  logic                     s2_valid_r;
  phase_t                   s2_phase_r;
  logic                     s2_disarm_r;
  logic signed [2*VelW+1:0] s2_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_phase_r  <= phase_nxt;
      s2_disarm_r <= s1_disarm;
      s2_prod_r   <= s1_prod;
    end
  end

  // neutral*1000 + product + 500, then split off the out-of-range cases
  logic [25:0]        neutral_k;
  logic signed [34:0] rnd_sum;
  logic               rnd_neg;
  logic               rnd_big;

  assign neutral_k = {neutral_r, 10'b0} - {6'b0, neutral_r, 4'b0} - {7'b0, neutral_r, 3'b0};
  assign rnd_sum   = $signed({9'b0, neutral_k}) + $signed({s2_prod_r[2*VelW+1], s2_prod_r})
                     + ROUND_HALF;
  assign rnd_neg   = rnd_sum[34];
  assign rnd_big   = !rnd_neg && (rnd_sum >= ROUND_SPAN);

  // ---------------- stage 3 ----------------
  logic        s3_valid_r;
  phase_t      s3_phase_r;
  logic        s3_disarm_r;
  logic        s3_neg_r;
  logic        s3_big_r;
  logic [25:0] s3_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_phase_r  <= s2_phase_r;
      s3_disarm_r <= s2_disarm_r;
      s3_neg_r    <= rnd_neg;
      s3_big_r    <= rnd_big;
      s3_sum_r    <= rnd_sum[25:0];
    end
  end

  // divide by 1000, clamp, pick throttle by phase
  logic [52:0]     quo_full;
  logic [ThrW-1:0] quo;
  logic [ThrW-1:0] thr_clamp;
  logic [ThrW-1:0] thr_sel;

  assign quo_full = {27'b0, s3_sum_r} * {26'b0, RECIP_1000};
  assign quo      = quo_full[RECIP_SHIFT+ThrW-1:RECIP_SHIFT];

  // negative result is below any minimum; overflow is above any maximum
  always_comb begin
    if (s3_neg_r)               thr_clamp = thr_min_r;
    else if (s3_big_r)          thr_clamp = thr_max_r;
    else if (quo < thr_min_r)   thr_clamp = thr_min_r;
    else if (quo > thr_max_r)   thr_clamp = thr_max_r;
    else                        thr_clamp = quo;
  end

  always_comb begin
    case (s3_phase_r)
      PH_DESCEND: thr_sel = thr_clamp;
      PH_FINAL:   thr_sel = final_thr_r;
      default:    thr_sel = '0;
    endcase
  end

  // ---------------- output register ----------------
  logic [ThrW-1:0] out_thr_r;
  phase_t          out_phase_r;
  logic            out_disarm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_thr_r    <= thr_sel;
      out_phase_r  <= s3_phase_r;
      out_disarm_r <= s3_disarm_r;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.throttle = out_thr_r;
  assign out_chan.phase    = out_phase_r;
  assign out_chan.disarm   = out_disarm_r;

endmodule
